@@ rtl/core/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and codes for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CP_W     = 31;
  localparam int CNT_W    = 3;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_CHAR    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TRUNC   = 2'd2;

  localparam logic [CNT_W-1:0] LEN_INVALID = 3'd0;
  localparam logic [CNT_W-1:0] LEN_ASCII   = 3'd1;

  // Classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0]       byte_value;
    logic             last_byte;
    logic [CNT_W-1:0] lead_len;
    logic [6:0]       lead_bits;
  } u8d_item_t;

endpackage

@@ rtl/core/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial decoder for legacy 1 to 6 byte UTF-8 sequences.
// ----------------------------------------------------------------------------
// Takes one byte beat per cycle and sustains that rate with out_stall low.
// A byte is classified on entry, waits in a QUEUE_DEPTH-entry FIFO and is
// merged into the open sequence by the decode stage, whose state update
// sets the rate. The decode stage registers a result beat from the byte
// that completes it (character, invalid lead byte or truncated
// sequence); bytes that only extend a sequence produce no beat. in_stall
// rises only when the FIFO is full because results are being held off.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
  parameter int QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte_value,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u8d_pkg::CP_W-1:0]      out_code_point,
  output logic [u8d_pkg::CNT_W-1:0]     out_byte_count,
  output logic [u8d_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_end_of_text
);
  import u8d_pkg::*;

  u8d_item_t push_item;
  u8d_item_t head_item;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_not_empty;

  u8d_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_value (in_byte_value),
    .in_last_byte  (in_last_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  u8d_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_item          (head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_byte_count  (out_byte_count),
    .out_status      (out_status),
    .out_end_of_text (out_end_of_text)
  );

endmodule

@@ rtl/core/u8d_front.sv @@
// ----------------------------------------------------------------------------
// u8d_front
// Accepts input beats and classifies each byte as a lead byte.
// ----------------------------------------------------------------------------
module u8d_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte_value,
  input  logic                  in_last_byte,
  input  logic                  q_full,
  output logic                  q_push,
  output u8d_pkg::u8d_item_t    q_item
);
  import u8d_pkg::*;

  logic [CNT_W-1:0] len;
  logic [6:0]       bits;

  always_comb begin
    len  = LEN_INVALID;
    bits = '0;
    unique casez (in_byte_value)
      8'b0???????: begin
        len  = LEN_ASCII;
        bits = in_byte_value[6:0];
      end
      8'b110?????: begin
        len  = 3'd2;
        bits = {2'b0, in_byte_value[4:0]};
      end
      8'b1110????: begin
        len  = 3'd3;
        bits = {3'b0, in_byte_value[3:0]};
      end
      8'b11110???: begin
        len  = 3'd4;
        bits = {4'b0, in_byte_value[2:0]};
      end
      8'b111110??: begin
        len  = 3'd5;
        bits = {5'b0, in_byte_value[1:0]};
      end
      8'b1111110?: begin
        len  = 3'd6;
        bits = {6'b0, in_byte_value[0]};
      end
      default: begin
        len  = LEN_INVALID;
        bits = '0;
      end
    endcase
  end

  assign in_stall            = q_full;
  assign q_push              = in_valid && !q_full;
  assign q_item.byte_value   = in_byte_value;
  assign q_item.last_byte    = in_last_byte;
  assign q_item.lead_len     = len;
  assign q_item.lead_bits    = bits;

endmodule

@@ rtl/core/u8d_queue.sv @@
// ----------------------------------------------------------------------------
// u8d_queue
// Small register FIFO between the classifier and the decode stage.
// ----------------------------------------------------------------------------
module u8d_queue #(
  parameter int DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  u8d_pkg::u8d_item_t   push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output u8d_pkg::u8d_item_t   head_item
);
  import u8d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  u8d_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_Q-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_Q'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/core/u8d_back.sv @@
// ----------------------------------------------------------------------------
// u8d_back
// Sequence state, continuation merge and the output register.
// ----------------------------------------------------------------------------
module u8d_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_not_empty,
  input  u8d_pkg::u8d_item_t            q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u8d_pkg::CP_W-1:0]      out_code_point,
  output logic [u8d_pkg::CNT_W-1:0]     out_byte_count,
  output logic [u8d_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_end_of_text
);
  import u8d_pkg::*;

  logic [CP_W-1:0]     partial_r, partial_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    seq_r, seq_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CP_W-1:0]     cp_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [STATUS_W-1:0] st_r;
  logic                eot_r;

  logic                emit;
  logic [CP_W-1:0]     emit_cp;
  logic [CNT_W-1:0]    emit_cnt;
  logic [STATUS_W-1:0] emit_st;
  logic [CP_W-1:0]     merged;
  logic [CNT_W-1:0]    rem_dec;

  assign q_pop   = q_not_empty && (!out_valid_r || !out_stall);
  assign merged  = {partial_r[CP_W-7:0], q_item.byte_value[5:0]};
  assign rem_dec = rem_r - 1'b1;

  always_comb begin
    partial_nxt = partial_r;
    rem_nxt     = rem_r;
    seq_nxt     = seq_r;
    emit        = 1'b0;
    emit_cp     = '0;
    emit_cnt    = LEN_ASCII;
    emit_st     = ST_CHAR;
    if (q_pop) begin
      if (rem_r == '0) begin
        if (q_item.lead_len == LEN_ASCII) begin
          emit    = 1'b1;
          emit_cp = CP_W'(q_item.lead_bits);
        end else if (q_item.lead_len == LEN_INVALID) begin
          emit    = 1'b1;
          emit_st = ST_INVALID;
        end else if (q_item.last_byte) begin
          emit    = 1'b1;
          emit_st = ST_TRUNC;
        end else begin
          partial_nxt = CP_W'(q_item.lead_bits);
          rem_nxt     = q_item.lead_len - 1'b1;
          seq_nxt     = q_item.lead_len;
        end
      end else if (rem_dec == '0) begin
        emit        = 1'b1;
        emit_cp     = merged;
        emit_cnt    = seq_r;
        partial_nxt = '0;
        rem_nxt     = '0;
        seq_nxt     = '0;
      end else if (q_item.last_byte) begin
        emit        = 1'b1;
        emit_st     = ST_TRUNC;
        emit_cnt    = seq_r - rem_dec;
        partial_nxt = '0;
        rem_nxt     = '0;
        seq_nxt     = '0;
      end else begin
        partial_nxt = merged;
        rem_nxt     = rem_dec;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r   <= '0;
      rem_r       <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      partial_r   <= partial_nxt;
      rem_r       <= rem_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cp_r  <= emit_cp;
      cnt_r <= emit_cnt;
      st_r  <= emit_st;
      eot_r <= q_item.last_byte;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_point  = cp_r;
  assign out_byte_count  = cnt_r;
  assign out_status      = st_r;
  assign out_end_of_text = eot_r;

endmodule

@@ rtl/core/u8d_checker.sv @@
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
module u8d_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [u8d_pkg::CP_W-1:0]      out_code_point,
  input logic [u8d_pkg::CNT_W-1:0]     out_byte_count,
  input logic [u8d_pkg::STATUS_W-1:0]  out_status,
  input logic                          out_end_of_text
);
  import u8d_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_point) &&
      $stable(out_byte_count) && $stable(out_status) && $stable(out_end_of_text))
    else $error("result beat changed while stalled");

  a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_CHAR |-> out_code_point == '0)
    else $error("error beat carries a code point");

  a_trunc_eot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TRUNC |-> out_end_of_text)
    else $error("truncated beat without end of text");

  a_invalid_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_INVALID |-> out_byte_count == LEN_ASCII)
    else $error("invalid lead beat with byte count other than one");

  a_char_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_CHAR |-> out_byte_count != '0 &&
      out_byte_count <= 3'd6)
    else $error("character beat with bad byte count");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_code_point  (out_code_point),
  .out_byte_count  (out_byte_count),
  .out_status      (out_status),
  .out_end_of_text (out_end_of_text)
);

@@ sim/utf8_stream_decoder_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_checker
// Watches both channels of the decoder, predicts every result beat from the
// accepted byte beats and compares the two in order.
// ----------------------------------------------------------------------------
// Keeps its own copy of the open sequence (gathered bits, bytes still due,
// length) and queues one expected beat per character, bad lead byte or cut
// sequence. Reports each mismatch and each unexpected beat, and exposes the
// failure count and the number of beats still due.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [7:0]                    in_byte_value,
  input  logic                          in_last_byte,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [u8d_pkg::CP_W-1:0]      out_code_point,
  input  logic [u8d_pkg::CNT_W-1:0]     out_byte_count,
  input  logic [u8d_pkg::STATUS_W-1:0]  out_status,
  input  logic                          out_end_of_text,
  output int                            fail_count,
  output int                            pending
);
  import u8d_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0]     code_point;
    logic [CNT_W-1:0]    byte_count;
    logic [STATUS_W-1:0] status;
    logic                end_of_text;
  } char_result_t;

  logic [CP_W-1:0]  seq_value;
  logic [CNT_W-1:0] seq_left;
  logic [CNT_W-1:0] seq_len;
  char_result_t     results_due[$];

  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output char_result_t res);
    logic [CNT_W-1:0] lead_len;
    logic [CP_W-1:0]  lead_bits;
    res = '0;
    res.end_of_text = last;
    if (seq_left == 0) begin
      lead_bits = '0;
      casez (b)
        8'b0???????: lead_len = LEN_ASCII;
        8'b110?????: begin
          lead_len  = 3'd2;
          lead_bits = CP_W'(b[4:0]);
        end
        8'b1110????: begin
          lead_len  = 3'd3;
          lead_bits = CP_W'(b[3:0]);
        end
        8'b11110???: begin
          lead_len  = 3'd4;
          lead_bits = CP_W'(b[2:0]);
        end
        8'b111110??: begin
          lead_len  = 3'd5;
          lead_bits = CP_W'(b[1:0]);
        end
        8'b1111110?: begin
          lead_len  = 3'd6;
          lead_bits = CP_W'(b[0]);
        end
        default: lead_len = LEN_INVALID;
      endcase
      if (lead_len == LEN_ASCII) begin
        res.code_point = CP_W'(b);
        res.byte_count = LEN_ASCII;
        res.status     = ST_CHAR;
        return 1'b1;
      end
      if (lead_len == LEN_INVALID) begin
        res.byte_count = 3'd1;
        res.status     = ST_INVALID;
        return 1'b1;
      end
      if (last) begin
        res.byte_count = 3'd1;
        res.status     = ST_TRUNC;
        return 1'b1;
      end
      seq_value = lead_bits;
      seq_left  = lead_len - 3'd1;
      seq_len   = lead_len;
      return 1'b0;
    end
    // continuation: top two bits ignored
    seq_value = {seq_value[CP_W-7:0], b[5:0]};
    seq_left  = seq_left - 3'd1;
    if (seq_left == 0) begin
      res.code_point = seq_value;
      res.byte_count = seq_len;
      res.status     = ST_CHAR;
      seq_value      = '0;
      seq_len        = '0;
      return 1'b1;
    end
    if (last) begin
      res.byte_count = seq_len - seq_left;
      res.status     = ST_TRUNC;
      seq_value      = '0;
      seq_left       = '0;
      seq_len        = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : monitor
    char_result_t want;
    char_result_t got;
    if (!rst_n) begin
      seq_value  = '0;
      seq_left   = '0;
      seq_len    = '0;
      results_due.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (decode_byte(in_byte_value, in_last_byte, want)) results_due.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = {out_code_point, out_byte_count, out_status, out_end_of_text};
        if (results_due.size() == 0) begin
          $display("%0t: result beat with none due: cp %h count %0d status %0d eot %0b",
                   $time, got.code_point, got.byte_count, got.status, got.end_of_text);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (got.code_point !== want.code_point || got.byte_count !== want.byte_count ||
              got.status !== want.status || got.end_of_text !== want.end_of_text) begin
            $display("%0t: expected cp %h count %0d status %0d eot %0b", $time,
                     want.code_point, want.byte_count, want.status, want.end_of_text);
            $display("%0t: actual   cp %h count %0d status %0d eot %0b", $time,
                     got.code_point, got.byte_count, got.status, got.end_of_text);
            fail_count++;
          end
        end
      end
    end
    pending = results_due.size();
  end

endmodule

@@ sim/utf8_stream_decoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Stimulus and verdict for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
// Sends a short directed set of byte beats (ASCII extremes, bad lead bytes,
// every sequence length, cut sequences, lead-like continuation bytes), then
// random texts made mostly of well-formed characters with some noise and
// cut-off endings. Both sides idle at random; one pause drains the decoder
// midway. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;
  import u8d_pkg::*;

  localparam int ITEM_TARGET  = 1250;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic [7:0]          in_byte_value = 8'h00;
  logic                in_last_byte  = 1'b0;
  logic                out_stall     = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [CP_W-1:0]     out_code_point;
  logic [CNT_W-1:0]    out_byte_count;
  logic [STATUS_W-1:0] out_status;
  logic                out_end_of_text;

  int         fail_count;
  int         pending;
  int         bytes_sent  = 0;
  int         idle_cycles = 0;
  int         stall_left  = 0;
  bit         in_gaps_on  = 1'b1;
  bit         out_gaps_on = 1'b1;
  bit         drained     = 1'b0;
  logic [7:0] text_q[$];

  always #5 clk = ~clk;

  utf8_stream_decoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_value   (in_byte_value),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_byte_count  (out_byte_count),
    .out_status      (out_status),
    .out_end_of_text (out_end_of_text)
  );

  utf8_stream_decoder_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_value   (in_byte_value),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_byte_count  (out_byte_count),
    .out_status      (out_status),
    .out_end_of_text (out_end_of_text),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // mostly short, a few long
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (out_gaps_on && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left = gap_length();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = in_gaps_on ? gap_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= b;
    in_last_byte  <= last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic push_char(input int len);
    logic [7:0] lead;
    case (len)
      1:       lead = {1'b0, 7'($urandom)};
      2:       lead = {3'b110, 5'($urandom)};
      3:       lead = {4'b1110, 4'($urandom)};
      4:       lead = {5'b11110, 3'($urandom)};
      5:       lead = {6'b111110, 2'($urandom)};
      default: lead = {7'b1111110, 1'($urandom)};
    endcase
    text_q.push_back(lead);
    repeat (len - 1) begin
      if ($urandom_range(0, 9) == 0) text_q.push_back(8'($urandom));
      else text_q.push_back({2'b10, 6'($urandom)});
    end
  endtask

  task automatic send_text();
    int r;
    int cut_len;
    text_q.delete();
    repeat ($urandom_range(1, 8)) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        case ($urandom_range(0, 9))
          0:       text_q.push_back(8'hFE);
          1:       text_q.push_back(8'hFF);
          default: text_q.push_back({2'b10, 6'($urandom)});
        endcase
      end else if (r < 40) push_char(1);
      else if (r < 55) push_char(2);
      else if (r < 70) push_char(3);
      else if (r < 82) push_char(4);
      else if (r < 91) push_char(5);
      else push_char(6);
    end
    // text ends inside a sequence
    if ($urandom_range(0, 6) == 0) begin
      cut_len = $urandom_range(2, 6);
      push_char(cut_len);
      repeat ($urandom_range(1, cut_len - 1)) void'(text_q.pop_back());
    end
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFD, 1'b0);
    repeat (5) send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'h88, 1'b1);
    send_byte(8'hE2, 1'b1);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'hBF, 1'b1);

    while (bytes_sent < ITEM_TARGET) begin
      case (bytes_sent / 250)
        1: begin
          in_gaps_on  = 1'b0;
          out_gaps_on = 1'b0;
        end
        2: begin
          in_gaps_on  = 1'b1;
          out_gaps_on = 1'b0;
        end
        3: begin
          in_gaps_on  = 1'b0;
          out_gaps_on = 1'b1;
        end
        default: begin
          in_gaps_on  = 1'b1;
          out_gaps_on = 1'b1;
        end
      endcase
      if (!drained && bytes_sent >= ITEM_TARGET / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        drained = 1'b1;
      end
      send_text();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
